// File: design/sexp_tok_pkg.sv
// shared types and constants for the s-expression tokenizer
// result record, push bundle, token and error codes, scan modes
// no dependencies
package sexp_tok_pkg;

  localparam int MAX_SOURCE_BYTES_DEF = 65536;
  localparam int MAX_PUSH = 3;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [3:0] KIND_LPAREN  = 4'd0;
  localparam logic [3:0] KIND_RPAREN  = 4'd1;
  localparam logic [3:0] KIND_LBRACK  = 4'd2;
  localparam logic [3:0] KIND_RBRACK  = 4'd3;
  localparam logic [3:0] KIND_QUOTE   = 4'd4;
  localparam logic [3:0] KIND_SYMBOL  = 4'd5;
  localparam logic [3:0] KIND_NUMBER  = 4'd6;
  localparam logic [3:0] KIND_STRING  = 4'd7;
  localparam logic [3:0] KIND_BOOLEAN = 4'd8;
  localparam logic [3:0] KIND_END     = 4'd9;
  localparam logic [3:0] KIND_ERROR   = 4'd10;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
  localparam logic [1:0] ERR_OPEN_STR   = 2'd2;
  localparam logic [1:0] ERR_TOO_LONG   = 2'd3;

  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_COMMENT  = 3'd1;
  localparam logic [2:0] MODE_STRING   = 3'd2;
  localparam logic [2:0] MODE_INTEGER  = 3'd3;
  localparam logic [2:0] MODE_FRACTION = 3'd4;
  localparam logic [2:0] MODE_SYMBOL   = 3'd5;

  localparam logic [15:0] SYM_TRUE  = 16'h2374;
  localparam logic [15:0] SYM_FALSE = 16'h2366;

  typedef struct packed {
    logic [3:0]  kind;
    logic [1:0]  err;
    logic [15:0] offset;
    logic [15:0] length;
    logic [15:0] line;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0]            cnt;
    res_t [MAX_PUSH-1:0]   res;
  } push_t;

endpackage

// File: design/s_expression_tokenizer_core.sv
// top level of the s-expression tokenizer
// instantiates sexp_tok_scan and sexp_tok_queue, depends on sexp_tok_pkg
//
//   channel | ports                                   | moves
//   in      | in_valid, in_stall, in_operation, ...   | one source byte or end marker
//   out     | out_valid, out_stall, out_token_kind... | one token record
//
// one input transaction per cycle into a holding register while in_stall is low, scanned once the queue has room
// a transaction yields zero to three records; the four-entry queue drains one per cycle while out_stall is low,
// so input stalls only while more than one record waits
// an accepted transaction passes the holding register and then the queue before its first record is offered
// rst_n clears the scan state (line 1, position 0) and empties the queue
module s_expression_tokenizer_core #(
  parameter int MAX_SOURCE_BYTES = sexp_tok_pkg::MAX_SOURCE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_kind,
  output logic [1:0]  out_error_kind,
  output logic [15:0] out_lexeme_offset,
  output logic [15:0] out_lexeme_length,
  output logic [15:0] out_line_number,
  output logic        out_last_of_run
);
  import sexp_tok_pkg::*;

  push_t push;
  logic  room;
  res_t  head;

  sexp_tok_scan #(
    .MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_data_byte (in_data_byte),
    .room         (room),
    .push         (push)
  );

  sexp_tok_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_token_kind    = head.kind;
  assign out_error_kind    = head.err;
  assign out_lexeme_offset = head.offset;
  assign out_lexeme_length = head.length;
  assign out_line_number   = head.line;
  assign out_last_of_run   = head.last;

endmodule

// File: design/sexp_tok_scan.sv
// input register and scan machine: one source transaction per cycle while the queue has room
// produces up to three result records per transaction
// depends on sexp_tok_pkg
module sexp_tok_scan #(
  parameter int MAX_SOURCE_BYTES = sexp_tok_pkg::MAX_SOURCE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_operation,
  input  logic [7:0]          in_data_byte,
  input  logic                room,
  output sexp_tok_pkg::push_t push
);
  import sexp_tok_pkg::*;

  localparam int POS_W = $clog2(MAX_SOURCE_BYTES + 1);
  localparam int EXT_W = (POS_W > 16) ? POS_W : 16;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_special(input logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "_" ||
           c == ">" || c == "<" || c == "=" || c == "!" || c == "?" ||
           c == ":" || c == "#" || c == "%" || c == "&" || c == "$" ||
           c == ".";
  endfunction

  function automatic logic is_body(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || is_special(c);
  endfunction

  function automatic res_t mk_res(input logic [3:0] kind, input logic [1:0] ek,
                                  input logic [POS_W-1:0] off,
                                  input logic [POS_W-1:0] len,
                                  input logic [15:0] line);
    logic [EXT_W-1:0] off_e;
    logic [EXT_W-1:0] len_e;
    res_t r;
    off_e = EXT_W'(off);
    len_e = EXT_W'(len);
    r.kind = kind;
    r.err = ek;
    r.offset = off_e[15:0];
    r.length = (len_e > EXT_W'(16'hFFFF)) ? 16'hFFFF : len_e[15:0];
    r.line = line;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic logic [3:0] sym_kind(input logic [POS_W-1:0] len,
                                          input logic [15:0] ft);
    if (len == POS_W'(2) && (ft == SYM_TRUE || ft == SYM_FALSE)) begin
      return KIND_BOOLEAN;
    end
    return KIND_SYMBOL;
  endfunction

  logic             hold_vld_r, hold_vld_nxt;
  logic             op_r;
  logic [7:0]       byte_r;
  logic             fire;
  logic             load;

  logic [2:0]       mode_r, mode_nxt;
  logic [POS_W-1:0] ts_r, ts_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      line_r, line_nxt;
  logic             hm_r, hm_nxt;
  logic             hd_r, hd_nxt;
  logic [15:0]      ft_r, ft_nxt;
  logic             err_r, err_nxt;

  res_t [MAX_PUSH-1:0] res_v;
  logic [1:0]          n;

  assign fire = hold_vld_r & room;
  assign in_stall = hold_vld_r & ~room;
  assign load = in_valid & ~in_stall;
  assign hold_vld_nxt = load | (hold_vld_r & ~fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r <= in_operation;
      byte_r <= in_data_byte;
    end
  end

  always_comb begin
    logic             do_start;
    logic             line_inc;
    logic [7:0]       c;
    logic [POS_W-1:0] p;
    do_start = 1'b0;
    line_inc = 1'b0;
    c = byte_r;
    p = pos_r;
    mode_nxt = mode_r;
    ts_nxt = ts_r;
    pos_nxt = pos_r;
    line_nxt = line_r;
    hm_nxt = hm_r;
    hd_nxt = hd_r;
    ft_nxt = ft_r;
    err_nxt = err_r;
    res_v = '0;
    n = 2'd0;

    if (fire) begin
      if (op_r == OP_END) begin
        if (!err_r) begin
          unique case (mode_r)
            MODE_STRING: begin
              res_v[n] = mk_res(KIND_ERROR, ERR_OPEN_STR, ts_r, p - ts_r, line_r);
              n = n + 2'd1;
            end
            MODE_INTEGER: begin
              if (hd_r) begin
                res_v[n] = mk_res(KIND_NUMBER, ERR_NONE, ts_r, p - POS_W'(1) - ts_r,
                                  line_r);
                n = n + 2'd1;
                res_v[n] = mk_res(KIND_SYMBOL, ERR_NONE, p - POS_W'(1), POS_W'(1),
                                  line_r);
                n = n + 2'd1;
              end else begin
                res_v[n] = mk_res(KIND_NUMBER, ERR_NONE, ts_r, p - ts_r, line_r);
                n = n + 2'd1;
              end
            end
            MODE_FRACTION: begin
              res_v[n] = mk_res(KIND_NUMBER, ERR_NONE, ts_r, p - ts_r, line_r);
              n = n + 2'd1;
            end
            MODE_SYMBOL: begin
              res_v[n] = mk_res(sym_kind(p - ts_r, ft_r), ERR_NONE, ts_r, p - ts_r,
                                line_r);
              n = n + 2'd1;
            end
            default: begin
            end
          endcase
          if (mode_r != MODE_STRING) begin
            res_v[n] = mk_res(KIND_END, ERR_NONE, p, '0, line_r);
            n = n + 2'd1;
          end
        end
      end else if (!err_r) begin
        if (pos_r >= POS_W'(MAX_SOURCE_BYTES)) begin
          res_v[n] = mk_res(KIND_ERROR, ERR_TOO_LONG, p, '0, line_r);
          n = n + 2'd1;
          err_nxt = 1'b1;
        end else begin
          pos_nxt = pos_r + POS_W'(1);
          unique case (mode_r)
            MODE_COMMENT: begin
              if (c == CH_NL) begin
                line_inc = 1'b1;
                mode_nxt = MODE_IDLE;
              end
            end
            MODE_STRING: begin
              if (c == CH_DQUOTE) begin
                res_v[n] = mk_res(KIND_STRING, ERR_NONE, ts_r + POS_W'(1),
                                  p - ts_r - POS_W'(1), line_r);
                n = n + 2'd1;
                mode_nxt = MODE_IDLE;
              end else if (c == CH_NL) begin
                line_inc = 1'b1;
              end
            end
            MODE_INTEGER: begin
              if (hd_r) begin
                hd_nxt = 1'b0;
                if (is_digit(c)) begin
                  mode_nxt = MODE_FRACTION;
                end else begin
                  res_v[n] = mk_res(KIND_NUMBER, ERR_NONE, ts_r,
                                    p - POS_W'(1) - ts_r, line_r);
                  n = n + 2'd1;
                  ts_nxt = p - POS_W'(1);
                  mode_nxt = MODE_SYMBOL;
                  if (is_body(c)) begin
                    ft_nxt = {CH_DOT, c};
                  end else begin
                    ft_nxt = {CH_DOT, 8'h00};
                    res_v[n] = mk_res(KIND_SYMBOL, ERR_NONE, p - POS_W'(1), POS_W'(1),
                                      line_r);
                    n = n + 2'd1;
                    do_start = 1'b1;
                  end
                end
              end else if (is_digit(c)) begin
              end else if (c == CH_DOT) begin
                hd_nxt = 1'b1;
              end else begin
                res_v[n] = mk_res(KIND_NUMBER, ERR_NONE, ts_r, p - ts_r, line_r);
                n = n + 2'd1;
                do_start = 1'b1;
              end
            end
            MODE_FRACTION: begin
              if (!is_digit(c)) begin
                res_v[n] = mk_res(KIND_NUMBER, ERR_NONE, ts_r, p - ts_r, line_r);
                n = n + 2'd1;
                do_start = 1'b1;
              end
            end
            MODE_SYMBOL: begin
              hm_nxt = 1'b0;
              if (hm_r && is_digit(c)) begin
                mode_nxt = MODE_INTEGER;
              end else if (is_body(c)) begin
                if (p - ts_r == POS_W'(1)) begin
                  ft_nxt = ft_r | {8'h00, c};
                end
              end else begin
                res_v[n] = mk_res(sym_kind(p - ts_r, ft_r), ERR_NONE, ts_r, p - ts_r,
                                  line_r);
                n = n + 2'd1;
                do_start = 1'b1;
              end
            end
            default: begin
              do_start = 1'b1;
            end
          endcase

          if (do_start) begin
            ts_nxt = p;
            mode_nxt = MODE_IDLE;
            case (c)
              CH_LPAREN: begin
                res_v[n] = mk_res(KIND_LPAREN, ERR_NONE, p, POS_W'(1), line_r);
                n = n + 2'd1;
              end
              CH_RPAREN: begin
                res_v[n] = mk_res(KIND_RPAREN, ERR_NONE, p, POS_W'(1), line_r);
                n = n + 2'd1;
              end
              CH_LBRACK: begin
                res_v[n] = mk_res(KIND_LBRACK, ERR_NONE, p, POS_W'(1), line_r);
                n = n + 2'd1;
              end
              CH_RBRACK: begin
                res_v[n] = mk_res(KIND_RBRACK, ERR_NONE, p, POS_W'(1), line_r);
                n = n + 2'd1;
              end
              CH_QUOTE: begin
                res_v[n] = mk_res(KIND_QUOTE, ERR_NONE, p, POS_W'(1), line_r);
                n = n + 2'd1;
              end
              CH_SPACE, CH_CR, CH_TAB: begin
              end
              CH_NL: begin
                line_inc = 1'b1;
              end
              CH_SEMI: begin
                mode_nxt = MODE_COMMENT;
              end
              CH_DQUOTE: begin
                mode_nxt = MODE_STRING;
              end
              default: begin
                if (is_digit(c)) begin
                  mode_nxt = MODE_INTEGER;
                end else if (c == CH_MINUS) begin
                  mode_nxt = MODE_SYMBOL;
                  hm_nxt = 1'b1;
                  ft_nxt = {c, 8'h00};
                end else if (is_alpha(c) || is_special(c)) begin
                  mode_nxt = MODE_SYMBOL;
                  ft_nxt = {c, 8'h00};
                end else begin
                  res_v[n] = mk_res(KIND_ERROR, ERR_UNEXPECTED, p, POS_W'(1), line_r);
                  n = n + 2'd1;
                  err_nxt = 1'b1;
                end
              end
            endcase
          end
        end
      end

      if (op_r == OP_END) begin
        mode_nxt = MODE_IDLE;
        ts_nxt = '0;
        pos_nxt = '0;
        line_nxt = 16'd1;
        hm_nxt = 1'b0;
        hd_nxt = 1'b0;
        ft_nxt = '0;
        err_nxt = 1'b0;
      end else if (line_inc && line_r != 16'hFFFF) begin
        line_nxt = line_r + 16'd1;
      end
    end

    if (n != 2'd0) begin
      res_v[n - 2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      ts_r <= '0;
      pos_r <= '0;
      line_r <= 16'd1;
      hm_r <= 1'b0;
      hd_r <= 1'b0;
      ft_r <= '0;
      err_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      ts_r <= ts_nxt;
      pos_r <= pos_nxt;
      line_r <= line_nxt;
      hm_r <= hm_nxt;
      hd_r <= hd_nxt;
      ft_r <= ft_nxt;
      err_r <= err_nxt;
    end
  end

  assign push.cnt = n;
  assign push.res = res_v;

endmodule

// File: design/sexp_tok_queue.sv
// four-entry result queue between the scan machine and the output channel
// takes up to three records per cycle, hands out one per transaction
// depends on sexp_tok_pkg
module sexp_tok_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  sexp_tok_pkg::push_t push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output sexp_tok_pkg::res_t  head
);
  import sexp_tok_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW = $clog2(DEPTH);

  res_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          pop;

  assign room = cnt_r <= (AW + 1)'(DEPTH - MAX_PUSH);
  assign out_valid = cnt_r != '0;
  assign pop = out_valid & ~out_stall;
  assign head = mem[rd_ptr_r];

  assign wr_ptr_nxt = wr_ptr_r + AW'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + AW'(pop);
  assign cnt_nxt = cnt_r + (AW + 1)'(push.cnt) - (AW + 1)'(pop);

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_PUSH; k++) begin
      if (2'(k) < push.cnt) begin
        mem[wr_ptr_r + AW'(k)] <= push.res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
